// ===== design/masked_byte_pattern_scan_macros.svh =====
// assertion macros shared by the scanner modules
// no dependencies; taken in by `include where checks are written
`ifndef MASKED_BYTE_PATTERN_SCAN_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCAN_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MBPS_CHECK_NOW(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("mbps check failed");

// consequent must hold in the cycle after the antecedent
`define MBPS_CHECK_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("mbps check failed");

`endif

// ===== design/mbps_pkg.sv =====
// shared types and constants for the masked byte pattern scanner
// no dependencies
package mbps_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int ADDR_W      = 32;

    // configuration register indices
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_CARE_MASK      = 3'd2,
        REG_PATTERN_LENGTH = 3'd3,
        REG_SCAN_BASE      = 3'd4,
        REG_MIN_START      = 3'd5
    } reg_index_t;

    // register values after reset (default signature)
    localparam logic [63:0]       RST_PATTERN_LOW    = 64'h0000_0005_DB10_768B;
    localparam logic [63:0]       RST_PATTERN_HIGH   = 64'h6AF8_45D9_F85D_D900;
    localparam logic [15:0]       RST_CARE_MASK      = 16'hFE1F;
    localparam logic [4:0]        RST_PATTERN_LENGTH = 5'd16;
    localparam logic [ADDR_W-1:0] RST_SCAN_BASE      = 32'h0040_0000;
    localparam logic [ADDR_W-1:0] RST_MIN_START      = 32'h0000_0000;

    // configuration register file contents
    typedef struct packed {
        logic [63:0]       pattern_low;
        logic [63:0]       pattern_high;
        logic [15:0]       care_mask;
        logic [4:0]        pattern_length;
        logic [ADDR_W-1:0] scan_base;
        logic [ADDR_W-1:0] min_start;
    } cfg_t;

    // per-byte status handed from the input stage to the compare stage
    typedef struct packed {
        logic              scan_first;
        logic              window_full;
        logic [ADDR_W-1:0] start_addr;
    } stage_t;

endpackage

// ===== design/mbps_cfg.sv =====
// configuration register file for the masked byte pattern scanner
// depends on mbps_pkg
module mbps_cfg #(
    parameter int MAX_PATTERN_BYTES = 16,
    localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [63:0]                       cfg_data,
    output mbps_pkg::cfg_t                    cfg,
    output logic [CNT_W-1:0]                  eff_len
);

    mbps_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register writes, unknown indices dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low    <= mbps_pkg::RST_PATTERN_LOW;
            cfg_reg.pattern_high   <= mbps_pkg::RST_PATTERN_HIGH;
            cfg_reg.care_mask      <= mbps_pkg::RST_CARE_MASK;
            cfg_reg.pattern_length <= mbps_pkg::RST_PATTERN_LENGTH;
            cfg_reg.scan_base      <= mbps_pkg::RST_SCAN_BASE;
            cfg_reg.min_start      <= mbps_pkg::RST_MIN_START;
        end
        else if (cfg_valid)
        begin
            unique case (mbps_pkg::reg_index_t'(cfg_index))
                mbps_pkg::REG_PATTERN_LOW:    cfg_reg.pattern_low    <= cfg_data;
                mbps_pkg::REG_PATTERN_HIGH:   cfg_reg.pattern_high   <= cfg_data;
                mbps_pkg::REG_CARE_MASK:      cfg_reg.care_mask      <= cfg_data[15:0];
                mbps_pkg::REG_PATTERN_LENGTH: cfg_reg.pattern_length <= cfg_data[4:0];
                mbps_pkg::REG_SCAN_BASE:
                    cfg_reg.scan_base <= cfg_data[mbps_pkg::ADDR_W-1:0];
                mbps_pkg::REG_MIN_START:
                    cfg_reg.min_start <= cfg_data[mbps_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // length in use: zero acts as one, clamp to the window depth
    always_comb
    begin
        priority if (cfg_reg.pattern_length == 5'd0)
            eff_len = CNT_W'(1);
        else if (cfg_reg.pattern_length > 5'(MAX_PATTERN_BYTES))
            eff_len = CNT_W'(MAX_PATTERN_BYTES);
        else
            eff_len = cfg_reg.pattern_length[CNT_W-1:0];
    end

endmodule

// ===== design/mbps_window.sv =====
// input stage: byte window shift line, byte count and address tracking
// depends on mbps_pkg and masked_byte_pattern_scan_macros.svh
`include "masked_byte_pattern_scan_macros.svh"

module mbps_window #(
    parameter int MAX_PATTERN_BYTES = 16,
    localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  take,
    input  logic [7:0]                            data_byte,
    input  logic                                  first_byte,
    input  logic [mbps_pkg::ADDR_W-1:0]           scan_base,
    input  logic [CNT_W-1:0]                      eff_len,
    output logic [MAX_PATTERN_BYTES-1:0][7:0]     window,
    output mbps_pkg::stage_t                      stage
);

    logic [MAX_PATTERN_BYTES-1:0][7:0] window_reg;
    logic [CNT_W-1:0]                  bytes_seen_reg;
    logic [CNT_W-1:0]                  bytes_seen_next;
    logic [mbps_pkg::ADDR_W-1:0]       cur_addr_reg;
    logic [mbps_pkg::ADDR_W-1:0]       byte_addr;
    mbps_pkg::stage_t                  stage_reg;

    assign window = window_reg;
    assign stage  = stage_reg;

    // count and address of the incoming byte
    always_comb
    begin
        if (first_byte)
        begin
            bytes_seen_next = CNT_W'(1);
            byte_addr       = scan_base;
        end
        else
        begin
            byte_addr = cur_addr_reg;
            if (bytes_seen_reg == CNT_W'(MAX_PATTERN_BYTES))
                bytes_seen_next = bytes_seen_reg;
            else
                bytes_seen_next = bytes_seen_reg + CNT_W'(1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            cur_addr_reg   <= '0;
        end
        else if (take)
        begin
            bytes_seen_reg <= bytes_seen_next;
            cur_addr_reg   <= byte_addr + 32'd1;
        end
    end

    // window shift and stage payload; entries beyond the count are never compared
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            window_reg[0] <= data_byte;
            for (int i = 1; i < MAX_PATTERN_BYTES; i++)
                window_reg[i] <= window_reg[i-1];
            stage_reg.scan_first  <= first_byte;
            stage_reg.window_full <= (bytes_seen_next >= eff_len);
            stage_reg.start_addr  <= byte_addr - 32'(eff_len) + 32'd1;
        end
    end

    `MBPS_CHECK_NOW(a_count_sat, clk, rst_n, 1'b1, bytes_seen_reg <= CNT_W'(MAX_PATTERN_BYTES))
    `MBPS_CHECK_NEXT(a_first_count, clk, rst_n, take && first_byte, bytes_seen_reg == CNT_W'(1))

endmodule

// ===== design/mbps_match.sv =====
// masked compare of the byte window against the signature
// depends on mbps_pkg
module mbps_match #(
    parameter int MAX_PATTERN_BYTES = 16,
    localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1),
    localparam int IDX_W = $clog2(MAX_PATTERN_BYTES)
) (
    input  logic [MAX_PATTERN_BYTES-1:0][7:0] window,
    input  mbps_pkg::cfg_t                    cfg,
    input  logic [CNT_W-1:0]                  eff_len,
    output logic                              hit
);

    logic [MAX_PATTERN_BYTES-1:0] byte_ok;

    // one lane per signature byte; window[len-1-k] is aligned with byte k
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++)
    begin : g_lane
        logic [7:0]       sig;
        logic [CNT_W-1:0] pos;
        logic             in_use;

        if (k < 8)
        begin : g_low
            assign sig = cfg.pattern_low[8*k +: 8];
        end
        else
        begin : g_high
            assign sig = cfg.pattern_high[8*(k-8) +: 8];
        end

        assign in_use     = (CNT_W'(k) < eff_len);
        assign pos        = eff_len - CNT_W'(k) - CNT_W'(1);
        assign byte_ok[k] = !(in_use && cfg.care_mask[k]) ||
                            (window[pos[IDX_W-1:0]] == sig);
    end

    assign hit = &byte_ok;

endmodule

// ===== design/masked_byte_pattern_scan.sv =====
// an accepted byte is registered into the window and stage, then its result into m_tvalid_reg
// throughput: one byte per cycle; input stalls only while a result waits untaken
// the rate is set by the window shift line feeding one masked compare, one byte a cycle
// reset: control state cleared, scan address 0, signature registers to the default pattern
// the window needs no clearing: only bytes of the current scan are ever compared
// depends on mbps_pkg, mbps_cfg, mbps_window, mbps_match and the macros header
`include "masked_byte_pattern_scan_macros.svh"

module masked_byte_pattern_scan #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [63:0]                       cfg_data,
    // byte stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tuser,   // [0] first_byte
    // match result out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata    // [31:0] match_address
);

    localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1);

    mbps_pkg::cfg_t                    cfg;
    mbps_pkg::stage_t                  stage;
    logic [CNT_W-1:0]                  eff_len;
    logic [MAX_PATTERN_BYTES-1:0][7:0] window;
    logic                              take;
    logic                              hit;
    logic                              s1_valid_reg;
    logic                              match_found_reg;
    logic                              found_eff;
    logic                              s1_emit;
    logic                              s1_move;
    logic                              m_tvalid_reg;
    logic [31:0]                       m_tdata_reg;

    mbps_cfg #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .eff_len   (eff_len)
    );

    mbps_window #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (s_tdata),
        .first_byte (s_tuser),
        .scan_base  (cfg.scan_base),
        .eff_len    (eff_len),
        .window     (window),
        .stage      (stage)
    );

    mbps_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .window  (window),
        .cfg     (cfg),
        .eff_len (eff_len),
        .hit     (hit)
    );

    // compare stage decision
    assign found_eff = stage.scan_first ? 1'b0 : match_found_reg;
    assign s1_emit   = s1_valid_reg && stage.window_full && !found_eff && hit &&
                       (stage.start_addr >= cfg.min_start);
    assign s1_move   = s1_valid_reg && (!s1_emit || !m_tvalid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || s1_move;
    assign take      = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // stage valid, found flag and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            match_found_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (take)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                match_found_reg <= found_eff || s1_emit;

            if (s1_move && s1_emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (s1_move && s1_emit)
            m_tdata_reg <= stage.start_addr;
    end

    `MBPS_CHECK_NEXT(a_found_after_emit, clk, rst_n, s1_move && s1_emit, match_found_reg && m_tvalid)
    `MBPS_CHECK_NOW(a_stall_cause, clk, rst_n, !s_tready, s1_valid_reg && m_tvalid_reg && !m_tready)
    `MBPS_CHECK_NOW(a_no_emit_found, clk, rst_n, s1_valid_reg && match_found_reg && !stage.scan_first, !s1_emit)

endmodule
